// ----- rtl/oas_pkg.sv -----
// Shared types and constants for the ordered array store.
`timescale 1ns / 1ps

package oas_pkg;

   localparam int COMMAND_W  = 3;
   localparam int INDEX_W    = 8;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int POSITION_W = 4;
   localparam int COUNT_W    = 5;
   localparam int LIMIT_W    = 5;
   // wide enough for any index, count or limit up to a capacity of 256
   localparam int CMP_W      = 9;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_REMOVE = 3'd4,
      CMD_FIND   = 3'd5,
      CMD_READ   = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_EVAL,
      SEQ_PUT,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  read_value;
      logic [POSITION_W-1:0]      position;
      logic                       found;
      logic [COUNT_W-1:0]         count;
      logic                       is_empty;
   } rsp_payload_type;

endpackage

// ----- rtl/oas_req_if.sv -----
// Command channel: valid/ready handshake with command, index and value.
`timescale 1ns / 1ps

interface oas_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [oas_pkg::COMMAND_W-1:0]        command;
   logic [oas_pkg::INDEX_W-1:0]          index;
   logic signed [oas_pkg::VALUE_W-1:0]   value;

   modport source (output valid, command, index, value, input ready);
   modport sink   (input valid, command, index, value, output ready);
endinterface

// ----- rtl/oas_rsp_if.sv -----
// Result channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps

interface oas_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [oas_pkg::STATUS_W-1:0]         status;
   logic signed [oas_pkg::VALUE_W-1:0]   read_value;
   logic [oas_pkg::POSITION_W-1:0]       position;
   logic                                 found;
   logic [oas_pkg::COUNT_W-1:0]          count;
   logic                                 is_empty;

   modport source (output valid, status, read_value, position, found, count, is_empty,
                   input ready);
   modport sink   (input valid, status, read_value, position, found, count, is_empty,
                   output ready);
endinterface

// ----- rtl/ordered_array_store_unit.sv -----
// Ordered array store: push, failed commands and unused codes need no memory read;
// pop and read at read one entry; find and remove scan entries in order; insert moves
// entries from the index up one place, then writes; delete moves those above it down.
// One command is in flight at a time; the single memory read port and shared compare
// visit one entry at a time. A finished result waits in an output register.
// Synchronous reset empties the store and sets the limit to 16; entries are not cleared.
`timescale 1ns / 1ps

module ordered_array_store_unit #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   oas_req_if.sink                       req_ch,
   oas_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [oas_pkg::LIMIT_W-1:0]   csr_wdata
);
   import oas_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic [LIMIT_W-1:0]  limit_ff;
   logic                rsp_valid_ff;
   rsp_payload_type     rsp_data_ff;

   logic                out_free;
   logic                done;
   rsp_payload_type     result;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [VALUE_W-1:0]  mem_wdata;
   logic                mem_re;
   logic [AW-1:0]       mem_raddr;
   logic [VALUE_W-1:0]  mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= result;
      end
   end

   oas_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_command (req_ch.command),
      .in_index   (req_ch.index),
      .in_value   (req_ch.value),
      .limit      (limit_ff),
      .out_free   (out_free),
      .done       (done),
      .result     (result),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   oas_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_data_ff.status;
   assign rsp_ch.read_value = rsp_data_ff.read_value;
   assign rsp_ch.position   = rsp_data_ff.position;
   assign rsp_ch.found      = rsp_data_ff.found;
   assign rsp_ch.count      = rsp_data_ff.count;
   assign rsp_ch.is_empty   = rsp_data_ff.is_empty;

endmodule

// ----- rtl/oas_mem.sv -----
// Entry storage: one write port and one registered read port.
`timescale 1ns / 1ps

module oas_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [AW-1:0]                   wr_addr,
   input  logic [oas_pkg::VALUE_W-1:0]     wr_data,
   input  logic                            rd_en,
   input  logic [AW-1:0]                   rd_addr,
   output logic [oas_pkg::VALUE_W-1:0]     rd_data
);
   import oas_pkg::*;

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

// ----- rtl/oas_ctrl.sv -----
// Command sequencer: walks the entries one read and one compare at a time.
`timescale 1ns / 1ps

module oas_ctrl #(
   parameter int CAPACITY = 16,
   parameter int AW       = 4,
   parameter int CW       = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [oas_pkg::COMMAND_W-1:0]     in_command,
   input  logic [oas_pkg::INDEX_W-1:0]       in_index,
   input  logic signed [oas_pkg::VALUE_W-1:0] in_value,
   input  logic [oas_pkg::LIMIT_W-1:0]       limit,
   input  logic                              out_free,
   output logic                              done,
   output oas_pkg::rsp_payload_type          result,
   output logic                              mem_we,
   output logic [AW-1:0]                     mem_waddr,
   output logic [oas_pkg::VALUE_W-1:0]       mem_wdata,
   output logic                              mem_re,
   output logic [AW-1:0]                     mem_raddr,
   input  logic [oas_pkg::VALUE_W-1:0]       mem_rdata
);
   import oas_pkg::*;

   seq_state_type             state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [VALUE_W-1:0]        val_ff, val_in;
   logic [AW-1:0]             ptr_ff, ptr_in;
   logic [CW-1:0]             wptr_ff, wptr_in;
   logic [CW-1:0]             count_ff, count_in;
   status_type                status_ff, status_in;
   logic [VALUE_W-1:0]        rd_ff, rd_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic                      fnd_ff, fnd_in;

   logic [CW-1:0]             cnt_dec;
   logic [CW-1:0]             w_next;
   logic [CMP_W-1:0]          count_w;
   logic [CMP_W-1:0]          index_w;
   logic [CMP_W-1:0]          limit_w;
   logic [CMP_W-1:0]          cap_w;
   logic [CMP_W-1:0]          ptr_w;
   logic [CMP_W-1:0]          pos_w;
   logic                      full;
   logic                      last;
   logic                      in_accept;

   assign cnt_dec   = count_ff - 1'b1;
   assign count_w   = CMP_W'(count_ff);
   assign index_w   = CMP_W'(in_index);
   assign cap_w     = CMP_W'(CAPACITY);
   assign limit_w   = (CMP_W'(limit) < cap_w) ? CMP_W'(limit) : cap_w;
   assign full      = (count_w >= limit_w);
   assign ptr_w     = CMP_W'(ptr_ff);
   assign last      = ((ptr_w + CMP_W'(1)) == count_w);
   assign in_accept = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      ptr_ff    <= ptr_in;
      wptr_ff   <= wptr_in;
      status_ff <= status_in;
      rd_ff     <= rd_in;
      pos_ff    <= pos_in;
      fnd_ff    <= fnd_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      ptr_in    = ptr_ff;
      wptr_in   = wptr_ff;
      count_in  = count_ff;
      status_in = status_ff;
      rd_in     = rd_ff;
      pos_in    = pos_ff;
      fnd_in    = fnd_ff;
      w_next    = wptr_ff;
      in_ready  = 1'b0;
      done      = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = ptr_ff;
      mem_wdata = mem_rdata;
      mem_re    = 1'b0;
      mem_raddr = ptr_ff;

      case (state_ff)
         SEQ_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd_in    = cmd_type'(in_command);
               idx_in    = in_index[AW-1:0];
               val_in    = in_value;
               status_in = ST_OK;
               rd_in     = '0;
               pos_in    = '0;
               fnd_in    = 1'b0;
               ptr_in    = '0;
               wptr_in   = '0;
               state_in  = SEQ_DONE;
               case (cmd_type'(in_command))
                  CMD_PUSH: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = in_value;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        count_in = cnt_dec;
                        ptr_in   = cnt_dec[AW-1:0];
                        state_in = SEQ_READ;
                     end
                  end
                  CMD_INSERT: begin
                     if (index_w >= count_w) begin
                        status_in = ST_RANGE;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        // shift from the top entry down to the insert point
                        ptr_in   = cnt_dec[AW-1:0];
                        state_in = SEQ_READ;
                     end
                  end
                  CMD_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (index_w >= count_w) begin
                        status_in = ST_RANGE;
                     end else if ((index_w + CMP_W'(1)) == count_w) begin
                        count_in = cnt_dec;
                     end else begin
                        ptr_in   = in_index[AW-1:0];
                        state_in = SEQ_READ;
                     end
                  end
                  CMD_REMOVE, CMD_FIND: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = SEQ_READ;
                     end
                  end
                  CMD_READ: begin
                     if (index_w >= count_w) begin
                        status_in = ST_RANGE;
                     end else begin
                        ptr_in   = in_index[AW-1:0];
                        state_in = SEQ_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         SEQ_READ: begin
            mem_re    = 1'b1;
            mem_raddr = (cmd_ff == CMD_DELETE) ? ptr_ff + 1'b1 : ptr_ff;
            state_in  = SEQ_EVAL;
         end

         SEQ_EVAL: begin
            state_in = SEQ_DONE;
            case (cmd_ff)
               CMD_POP, CMD_READ: begin
                  rd_in = mem_rdata;
               end
               CMD_INSERT: begin
                  mem_we    = 1'b1;
                  mem_waddr = ptr_ff + 1'b1;
                  if (ptr_ff == idx_ff) begin
                     state_in = SEQ_PUT;
                  end else begin
                     ptr_in   = ptr_ff - 1'b1;
                     state_in = SEQ_READ;
                  end
               end
               CMD_DELETE: begin
                  mem_we = 1'b1;
                  ptr_in = ptr_ff + 1'b1;
                  if ((ptr_w + CMP_W'(2)) == count_w) begin
                     count_in = cnt_dec;
                  end else begin
                     state_in = SEQ_READ;
                  end
               end
               CMD_REMOVE: begin
                  // keep survivors packed behind the write pointer
                  if (mem_rdata != val_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = wptr_ff[AW-1:0];
                     w_next    = wptr_ff + 1'b1;
                  end
                  wptr_in = w_next;
                  if (last) begin
                     count_in = w_next;
                  end else begin
                     ptr_in   = ptr_ff + 1'b1;
                     state_in = SEQ_READ;
                  end
               end
               CMD_FIND: begin
                  if (mem_rdata == val_ff) begin
                     fnd_in = 1'b1;
                     pos_in = ptr_ff;
                  end else if (last) begin
                     status_in = ST_NOTFOUND;
                  end else begin
                     ptr_in   = ptr_ff + 1'b1;
                     state_in = SEQ_READ;
                  end
               end
               default: begin
               end
            endcase
         end

         SEQ_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = val_ff;
            count_in  = count_ff + 1'b1;
            state_in  = SEQ_DONE;
         end

         SEQ_DONE: begin
            // hold until the result register can take this transfer
            if (out_free) begin
               done     = 1'b1;
               state_in = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign pos_w = CMP_W'(pos_ff);

   always_comb begin
      result.status     = status_ff;
      result.read_value = rd_ff;
      result.position   = pos_w[POSITION_W-1:0];
      result.found      = fnd_ff;
      result.count      = count_w[COUNT_W-1:0];
      result.is_empty   = (count_ff == '0);
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_w <= cap_w)
      else $error("entry count above capacity");

   a_idle_count_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_IDLE && !in_accept) |=> $stable(count_ff))
      else $error("entry count moved with no command in progress");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> (state_ff == SEQ_IDLE))
      else $error("sequencer did not return to idle after a result");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (done && result.found) |-> (result.status == ST_OK))
      else $error("find reported a match with a failing status");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_EVAL && (cmd_ff == CMD_REMOVE || cmd_ff == CMD_FIND))
         |-> (ptr_w < count_w))
      else $error("scan pointer beyond stored entries");

endmodule
